### hw/rtl/qrs_pkg.sv
// shared constants and solution codes for the quadratic root solver
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_ITERS_DEF  = 64;

  localparam int KIND_WIDTH   = 3;
  localparam int OUT_WIDTH    = 41;
  localparam int TOL_WIDTH    = 32;
  localparam int TOL_REF_FRAC = 16;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd655360;

  localparam logic [63:0] OUT_POS_LIM = (64'd1 << (OUT_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] OUT_NEG_LIM = 64'd1 << (OUT_WIDTH - 1);

  localparam logic [KIND_WIDTH-1:0] KIND_IDENTITY      = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_CONTRADICTION = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_LINEAR        = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_DOUBLE        = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_TWO_REAL      = 3'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_COMPLEX       = 3'd5;

  typedef struct packed {
    logic push;
    logic full;
  } qrs_queue_ctl_t;

endpackage

### hw/rtl/qrs_div.sv
// serial restoring divider, one quotient bit a cycle
module qrs_div #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  output logic             done,
  output logic [WIDTH-1:0] quo
);

  localparam int CNTW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CNTW-1:0]  count;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  always_comb begin
    trial = {rem, quo[WIDTH-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNTW'(WIDTH);
        rem   <= '0;
        quo   <= num;
        dsr   <= den;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= trial[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        count <= count - CNTW'(1);
        if (count == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/qrs_queue.sv
// two-entry queue between front and back
module qrs_queue #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qrs_pkg::qrs_queue_ctl_t wr_ctl,
  output logic                   full,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   pop,
  output logic                   rd_valid,
  output logic [WIDTH-1:0]       rd_data
);

  localparam int DEPTH = 2;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic             rd_next;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNTW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_push  = wr_ctl.push && !full;
  assign do_pop   = pop && rd_valid;
  assign rd_next  = do_pop ? !rd_ptr : rd_ptr;

  // head word is kept ready, a word pushed straight to the head is forwarded
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (do_push && (wr_ptr == rd_next)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

### hw/rtl/qrs_front.sv
// front end: takes coefficients, forms the discriminant and classifies
module qrs_front #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COEF_WIDTH-1:0]       coef_quad,
  input  logic signed [COEF_WIDTH-1:0]       coef_lin,
  input  logic signed [COEF_WIDTH-1:0]       coef_const,
  output qrs_pkg::qrs_queue_ctl_t            q_ctl,
  input  logic                               q_full,
  output logic [qrs_pkg::KIND_WIDTH+5*COEF_WIDTH:0] q_data
);

  localparam int PW = 2 * COEF_WIDTH;
  localparam int DW = 2 * COEF_WIDTH + 2;
  localparam int MW = 2 * COEF_WIDTH + 1;

  logic                         s1v;
  logic signed [COEF_WIDTH-1:0] a;
  logic signed [COEF_WIDTH-1:0] b;
  logic signed [COEF_WIDTH-1:0] c;
  logic signed [PW-1:0]         bb;
  logic signed [PW-1:0]         ac;
  logic signed [DW-1:0]         disc;
  logic [DW-1:0]                dabs;
  logic [qrs_pkg::KIND_WIDTH-1:0] kind;

  assign in_stall = s1v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else if (!s1v && in_valid) begin
      s1v <= 1'b1;
    end else if (s1v && !q_full) begin
      s1v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1v && in_valid) begin
      a  <= coef_quad;
      b  <= coef_lin;
      c  <= coef_const;
      bb <= coef_lin * coef_lin;
      ac <= coef_quad * coef_const;
    end
  end

  always_comb begin
    disc = DW'(bb) - (DW'(ac) <<< 2);
    dabs = disc[DW-1] ? DW'(-disc) : DW'(disc);
    if (a == '0) begin
      if (b != '0) begin
        kind = qrs_pkg::KIND_LINEAR;
      end else if (c != '0) begin
        kind = qrs_pkg::KIND_CONTRADICTION;
      end else begin
        kind = qrs_pkg::KIND_IDENTITY;
      end
    end else if (disc == '0) begin
      kind = qrs_pkg::KIND_DOUBLE;
    end else if (disc[DW-1]) begin
      kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      kind = qrs_pkg::KIND_TWO_REAL;
    end
  end

  assign q_ctl.push = s1v;
  assign q_ctl.full = q_full;
  assign q_data     = {kind, a, b, c, dabs[MW-1:0]};

endmodule

### hw/rtl/qrs_back.sv
// back end: newton square root and final root divisions on a shared divider
module qrs_back #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_ITERS  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                task_valid,
  input  logic [qrs_pkg::KIND_WIDTH+5*COEF_WIDTH:0] task_data,
  output logic                                task_pop,
  input  logic [qrs_pkg::TOL_WIDTH-1:0]       tol,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [qrs_pkg::KIND_WIDTH-1:0]      solution_kind,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_one_real,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_two_real,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] imag_part,
  output logic                                iteration_capped
);

  localparam int CW    = COEF_WIDTH;
  localparam int KW    = qrs_pkg::KIND_WIDTH;
  localparam int OW    = qrs_pkg::OUT_WIDTH;
  localparam int MW    = 2 * CW + 1;
  localparam int DW    = MW + FRAC_BITS;
  localparam int NW    = DW + 1;
  localparam int SW    = (DW + 1 > OW + 1) ? DW + 1 : OW + 1;
  localparam int TOLW  = qrs_pkg::TOL_WIDTH + FRAC_BITS;
  localparam int CMPW  = (DW > TOLW) ? DW : TOLW;
  localparam int TSH_L = (FRAC_BITS >= qrs_pkg::TOL_REF_FRAC) ?
                         FRAC_BITS - qrs_pkg::TOL_REF_FRAC : 0;
  localparam int TSH_R = (FRAC_BITS < qrs_pkg::TOL_REF_FRAC) ?
                         qrs_pkg::TOL_REF_FRAC - FRAC_BITS : 0;
  localparam int ITW   = $clog2(MAX_ITERS + 1);
  localparam int XW    = DW + 32;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NDIV   = 4'd1;
  localparam logic [3:0] S_NWAIT  = 4'd2;
  localparam logic [3:0] S_NSQ    = 4'd3;
  localparam logic [3:0] S_NCHK   = 4'd4;
  localparam logic [3:0] S_D1     = 4'd5;
  localparam logic [3:0] S_D1WAIT = 4'd6;
  localparam logic [3:0] S_D2WAIT = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]            state;
  logic [KW-1:0]         kind;
  logic signed [CW-1:0]  a;
  logic signed [CW-1:0]  b;
  logic signed [CW-1:0]  c;
  logic [MW-1:0]         dmag;
  logic [DW-1:0]         p;
  logic [ITW-1:0]        iters;
  logic                  capped;
  logic [63:0]           sq;
  logic                  ipok;
  logic [OW-1:0]         r1;
  logic [OW-1:0]         r2;
  logic [OW-1:0]         im;

  logic                  div_start;
  logic [DW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  logic                  div_neg;
  logic                  div_done;
  logic [DW-1:0]         div_quo;

  logic [KW-1:0]         t_kind;
  logic [CW-1:0]         t_a;
  logic [CW-1:0]         t_b;
  logic [CW-1:0]         t_c;
  logic [MW-1:0]         t_dmag;

  logic [TOLW-1:0]       tol_s;
  logic [DW-1:0]         diff;
  logic [DW:0]           psum;
  logic [DW-1:0]         pnext;
  logic [XW-1:0]         ipx;

  logic signed [NW-1:0]  bsx;
  logic signed [NW-1:0]  csx;
  logic signed [NW-1:0]  nb;
  logic signed [NW-1:0]  nc;
  logic signed [NW-1:0]  sx;
  logic signed [NW-1:0]  num1;
  logic signed [NW-1:0]  num2;
  logic signed [NW-1:0]  nsel;
  logic [NW-1:0]         nmag;
  logic signed [CW:0]    den;
  logic [CW:0]           dabs;
  logic [OW-1:0]         res;

  function automatic logic [OW-1:0] sat_out(input logic [DW-1:0] m, input logic neg);
    logic [SW-1:0] mx;
    logic [SW-1:0] val;
    mx  = SW'(m);
    val = neg ? SW'(-mx) : mx;
    if (!neg && (mx > SW'(qrs_pkg::OUT_POS_LIM))) begin
      return OW'(qrs_pkg::OUT_POS_LIM);
    end else if (neg && (mx > SW'(qrs_pkg::OUT_NEG_LIM))) begin
      return OW'(qrs_pkg::OUT_NEG_LIM);
    end
    return val[OW-1:0];
  endfunction

  qrs_div #(.WIDTH(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign {t_kind, t_a, t_b, t_c, t_dmag} = task_data;
  assign task_pop = (state == S_IDLE) && task_valid;

  always_comb begin
    tol_s = (TOLW'(tol) << TSH_L) >> TSH_R;
    diff  = (p > div_quo) ? p - div_quo : div_quo - p;
    psum  = (DW+1)'(p) + (DW+1)'(div_quo);
    pnext = (psum[DW:1] == '0) ? DW'(1) : psum[DW:1];
    ipx   = XW'(p) >> FRAC_BITS;
    bsx   = NW'(b);
    csx   = NW'(c);
    nb    = -(bsx <<< FRAC_BITS);
    nc    = -(csx <<< FRAC_BITS);
    sx    = $signed(NW'(p));
    if (kind == qrs_pkg::KIND_LINEAR) begin
      num1 = nc;
    end else if (kind == qrs_pkg::KIND_TWO_REAL) begin
      num1 = nb - sx;
    end else begin
      num1 = nb;
    end
    num2  = (kind == qrs_pkg::KIND_TWO_REAL) ? nb + sx : -sx;
    den   = (kind == qrs_pkg::KIND_LINEAR) ? (CW+1)'(b) : ((CW+1)'(a) <<< 1);
    dabs  = den[CW] ? (CW+1)'(-den) : (CW+1)'(den);
    nsel  = (state == S_D1) ? num1 : num2;
    nmag  = nsel[NW-1] ? NW'(-nsel) : NW'(nsel);
    res   = sat_out(div_quo, div_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (task_valid) begin
            kind   <= t_kind;
            a      <= t_a;
            b      <= t_b;
            c      <= t_c;
            dmag   <= t_dmag;
            capped <= 1'b0;
            iters  <= '0;
            p      <= DW'(t_dmag) << (FRAC_BITS - 1);
            r1     <= '0;
            r2     <= '0;
            im     <= '0;
            case (t_kind)
              qrs_pkg::KIND_LINEAR, qrs_pkg::KIND_DOUBLE: state <= S_D1;
              qrs_pkg::KIND_TWO_REAL, qrs_pkg::KIND_COMPLEX: state <= S_NDIV;
              default: state <= S_OUT;
            endcase
          end
        end
        S_NDIV: begin
          div_start <= 1'b1;
          div_num   <= DW'(dmag) << FRAC_BITS;
          div_den   <= p;
          state     <= S_NWAIT;
        end
        S_NWAIT: begin
          if (div_done) begin
            if (CMPW'(diff) <= CMPW'(tol_s)) begin
              state <= S_D1;
            end else if (iters >= ITW'(MAX_ITERS)) begin
              capped <= 1'b1;
              state  <= S_D1;
            end else begin
              p     <= pnext;
              iters <= iters + ITW'(1);
              state <= S_NSQ;
            end
          end
        end
        S_NSQ: begin
          ipok  <= (p[FRAC_BITS-1:0] == '0) && (ipx[XW-1:32] == '0);
          sq    <= ipx[31:0] * ipx[31:0];
          state <= S_NCHK;
        end
        S_NCHK: begin
          state <= (ipok && sq == 64'(dmag)) ? S_D1 : S_NDIV;
        end
        S_D1: begin
          div_start <= 1'b1;
          div_num   <= nmag[DW-1:0];
          div_den   <= DW'(dabs);
          div_neg   <= nsel[NW-1] ^ den[CW];
          state     <= S_D1WAIT;
        end
        S_D1WAIT: begin
          if (div_done) begin
            r1 <= res;
            case (kind)
              qrs_pkg::KIND_DOUBLE: begin
                r2    <= res;
                state <= S_OUT;
              end
              qrs_pkg::KIND_COMPLEX, qrs_pkg::KIND_TWO_REAL: begin
                if (kind == qrs_pkg::KIND_COMPLEX) begin
                  r2 <= res;
                end
                div_start <= 1'b1;
                div_num   <= nmag[DW-1:0];
                div_den   <= DW'(dabs);
                div_neg   <= nsel[NW-1] ^ den[CW];
                state     <= S_D2WAIT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_D2WAIT: begin
          if (div_done) begin
            if (kind == qrs_pkg::KIND_TWO_REAL) begin
              r2 <= res;
            end else begin
              im <= res;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      solution_kind    <= kind;
      root_one_real    <= r1;
      root_two_real    <= r2;
      imag_part        <= im;
      iteration_capped <= capped;
    end
  end

endmodule

### hw/rtl/quadratic_root_solver.sv
// top level of the quadratic root solver
// Solves a*x*x + b*x + c = 0 for signed integer coefficients, one result word per
// input word, giving the solution kind, two roots (or the real part) and the
// imaginary part in signed Q24.16 with saturation. The front end holds one word and
// takes the next only once that word has gone into the queue; the back end does the work with a
// single serial divider of W = 2*COEF_WIDTH + 1 + FRAC_BITS bits (49 by default),
// one quotient bit a cycle. Linear and double roots need one root division.
// Real-pair and complex cases need two root divisions after the Newton loop, which
// takes one division and then, for each of up to MAX_ITERS updates, a square check
// in S_NSQ and S_NCHK and, unless that finds an exact root, a further division.
// The tolerance register is written with tol_write.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITERS  = qrs_pkg::MAX_ITERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COEF_WIDTH-1:0]         coef_quad,
  input  logic signed [COEF_WIDTH-1:0]         coef_lin,
  input  logic signed [COEF_WIDTH-1:0]         coef_const,
  input  logic                                 tol_write,
  input  logic [qrs_pkg::TOL_WIDTH-1:0]        tol_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [qrs_pkg::KIND_WIDTH-1:0]       solution_kind,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_one_real,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_two_real,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] imag_part,
  output logic                                 iteration_capped
);

  localparam int TW = qrs_pkg::KIND_WIDTH + 5 * COEF_WIDTH + 1;

  logic [qrs_pkg::TOL_WIDTH-1:0] sqrt_tolerance;
  qrs_pkg::qrs_queue_ctl_t       q_ctl;
  logic                          q_full;
  logic [TW-1:0]                 q_wdata;
  logic                          q_valid;
  logic [TW-1:0]                 q_rdata;
  logic                          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_tolerance <= qrs_pkg::TOL_RESET;
    end else if (tol_write) begin
      sqrt_tolerance <= tol_data;
    end
  end

  qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coef_quad  (coef_quad),
    .coef_lin   (coef_lin),
    .coef_const (coef_const),
    .q_ctl      (q_ctl),
    .q_full     (q_full),
    .q_data     (q_wdata)
  );

  qrs_queue #(.WIDTH(TW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_ctl   (q_ctl),
    .full     (q_full),
    .wr_data  (q_wdata),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  qrs_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_ITERS  (MAX_ITERS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .task_valid       (q_valid),
    .task_data        (q_rdata),
    .task_pop         (q_pop),
    .tol              (sqrt_tolerance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .solution_kind    (solution_kind),
    .root_one_real    (root_one_real),
    .root_two_real    (root_two_real),
    .imag_part        (imag_part),
    .iteration_capped (iteration_capped)
  );

endmodule

### hw/rtl/qrs_checker.sv
// port-level checks for the quadratic root solver, bound to the top level
module qrs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [qrs_pkg::KIND_WIDTH-1:0]       solution_kind,
  input logic signed [qrs_pkg::OUT_WIDTH-1:0] root_one_real,
  input logic signed [qrs_pkg::OUT_WIDTH-1:0] root_two_real,
  input logic signed [qrs_pkg::OUT_WIDTH-1:0] imag_part,
  input logic                                 iteration_capped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(solution_kind) &&
      $stable(root_one_real) && $stable(root_two_real) && $stable(imag_part))
    else $error("result word changed while stalled");

  a_no_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && (solution_kind == qrs_pkg::KIND_IDENTITY ||
      solution_kind == qrs_pkg::KIND_CONTRADICTION) |->
      root_one_real == '0 && root_two_real == '0 && imag_part == '0 &&
      !iteration_capped)
    else $error("degenerate equation with nonzero roots");

  a_linear: assert property (@(posedge clk) disable iff (rst)
    out_valid && solution_kind == qrs_pkg::KIND_LINEAR |->
      root_two_real == '0 && imag_part == '0 && !iteration_capped)
    else $error("linear result malformed");

  a_double: assert property (@(posedge clk) disable iff (rst)
    out_valid && solution_kind == qrs_pkg::KIND_DOUBLE |->
      root_one_real == root_two_real && imag_part == '0 && !iteration_capped)
    else $error("double root malformed");

  a_complex: assert property (@(posedge clk) disable iff (rst)
    out_valid && solution_kind == qrs_pkg::KIND_COMPLEX |->
      root_one_real == root_two_real)
    else $error("complex pair real parts differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .solution_kind    (solution_kind),
  .root_one_real    (root_one_real),
  .root_two_real    (root_two_real),
  .imag_part        (imag_part),
  .iteration_capped (iteration_capped)
);

### dv/tb_quadratic_root_solver.sv
// self-checking testbench for the quadratic root solver with an in-bench root predictor
`timescale 1ns / 100ps

module tb_quadratic_root_solver;

  localparam int CW = qrs_pkg::COEF_WIDTH_DEF;
  localparam int FB = qrs_pkg::FRAC_BITS_DEF;
  localparam int ITER_CAP = qrs_pkg::MAX_ITERS_DEF;
  localparam int KW = qrs_pkg::KIND_WIDTH;
  localparam int OW = qrs_pkg::OUT_WIDTH;
  localparam int TLW = qrs_pkg::TOL_WIDTH;
  localparam logic [63:0] INNER_LIM = (64'd1 << 62) - 64'd1;
  localparam longint Q_MAX = (64'sd1 <<< 40) - 64'sd1;
  localparam longint Q_MIN = -Q_MAX - 64'sd1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 4000;

  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_word_t;

  typedef struct {
    logic [KW-1:0]        kind;
    logic signed [OW-1:0] r1;
    logic signed [OW-1:0] r2;
    logic signed [OW-1:0] im;
    logic                 capped;
  } root_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] coef_quad = '0;
  logic signed [CW-1:0] coef_lin = '0;
  logic signed [CW-1:0] coef_const = '0;
  logic tol_write = 1'b0;
  logic [TLW-1:0] tol_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KW-1:0] solution_kind;
  logic signed [OW-1:0] root_one_real;
  logic signed [OW-1:0] root_two_real;
  logic signed [OW-1:0] imag_part;
  logic iteration_capped;

  coef_word_t coef_pending[$];
  root_word_t roots_due[$];
  logic [TLW-1:0] tol_now = qrs_pkg::TOL_RESET;
  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;
  int long_hold = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit send_hold = 1'b0;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_quad(coef_quad), .coef_lin(coef_lin), .coef_const(coef_const),
    .tol_write(tol_write), .tol_data(tol_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .solution_kind(solution_kind), .root_one_real(root_one_real),
    .root_two_real(root_two_real), .imag_part(imag_part),
    .iteration_capped(iteration_capped)
  );

  always #6 clk = ~clk;

  // d * 2^FB / p, long division with saturation
  function automatic logic [63:0] fixed_quotient(logic [63:0] d, logic [63:0] p);
    logic [63:0] r;
    logic [63:0] q;
    logic bitv;
    r = '0;
    q = '0;
    if (p == 0) return INNER_LIM;
    for (int i = 63 + FB; i >= 0; i--) begin
      bitv = (i >= FB) ? d[i-FB] : 1'b0;
      r = {r[62:0], bitv};
      q = q << 1;
      if (r >= p) begin
        r = r - p;
        q[0] = 1'b1;
      end
      if (q > INNER_LIM) q = INNER_LIM;
    end
    return q;
  endfunction

  function automatic bit is_exact_root(logic [63:0] p, logic [63:0] d);
    logic [63:0] ip;
    ip = p >> FB;
    if (p[FB-1:0] != 0) return 1'b0;
    if (ip >= (64'd1 << 32)) return 1'b0;
    return (ip * ip) == d;
  endfunction

  function automatic logic [63:0] newton_root(logic [63:0] d, logic [TLW-1:0] tol_reg,
                                              output logic capped);
    logic [63:0] tol;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] diff;
    int iters;
    tol = (FB >= qrs_pkg::TOL_REF_FRAC) ? (64'(tol_reg) << (FB - qrs_pkg::TOL_REF_FRAC))
                                        : (64'(tol_reg) >> (qrs_pkg::TOL_REF_FRAC - FB));
    p = (d > (INNER_LIM >> (FB - 1))) ? INNER_LIM : (d << (FB - 1));
    iters = 0;
    capped = 1'b0;
    forever begin
      q = fixed_quotient(d, p);
      diff = (p > q) ? p - q : q - p;
      if (diff <= tol) break;
      if (iters >= ITER_CAP) begin
        capped = 1'b1;
        break;
      end
      p = (p + q) >> 1;
      iters++;
      if (p == 0) p = 1;
      if (is_exact_root(p, d)) break;
    end
    return p;
  endfunction

  function automatic logic signed [OW-1:0] clamp_q(longint v);
    if (v > Q_MAX) v = Q_MAX;
    if (v < Q_MIN) v = Q_MIN;
    return v[OW-1:0];
  endfunction

  function automatic root_word_t solve_roots(coef_word_t w, logic [TLW-1:0] tol_reg);
    root_word_t res;
    longint a, b, c, one, r1, r2, im, disc, den, s;
    logic cap;
    a = w.a;
    b = w.b;
    c = w.c;
    one = 64'sd1 <<< FB;
    r1 = 0;
    r2 = 0;
    im = 0;
    cap = 1'b0;
    if (a == 0) begin
      if (b != 0) begin
        res.kind = qrs_pkg::KIND_LINEAR;
        r1 = (-c * one) / b;
      end else if (c != 0) res.kind = qrs_pkg::KIND_CONTRADICTION;
      else res.kind = qrs_pkg::KIND_IDENTITY;
    end else begin
      den = 2 * a;
      disc = b * b - 4 * a * c;
      if (disc > 0) begin
        res.kind = qrs_pkg::KIND_TWO_REAL;
        s = longint'(newton_root(disc, tol_reg, cap));
        r1 = (-b * one - s) / den;
        r2 = (-b * one + s) / den;
      end else if (disc < 0) begin
        res.kind = qrs_pkg::KIND_COMPLEX;
        s = longint'(newton_root(-disc, tol_reg, cap));
        r1 = (-b * one) / den;
        r2 = r1;
        im = -s / den;
      end else begin
        res.kind = qrs_pkg::KIND_DOUBLE;
        r1 = (-b * one) / den;
        r2 = r1;
      end
    end
    res.r1 = clamp_q(r1);
    res.r2 = clamp_q(r2);
    res.im = clamp_q(im);
    res.capped = cap;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        roots_due.push_back(solve_roots('{coef_quad, coef_lin, coef_const}, tol_now));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (coef_pending.size() > 0 && !send_hold) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 5);
            in_valid <= 1'b0;
          end else begin
            coef_word_t w;
            w = coef_pending.pop_front();
            coef_quad <= w.a;
            coef_lin <= w.b;
            coef_const <= w.c;
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (roots_due.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          root_word_t e;
          e = roots_due.pop_front();
          if (solution_kind !== e.kind) report_mismatch("solution_kind", solution_kind, e.kind);
          if (root_one_real !== e.r1) report_mismatch("root_one_real", root_one_real, e.r1);
          if (root_two_real !== e.r2) report_mismatch("root_two_real", root_two_real, e.r2);
          if (imag_part !== e.im) report_mismatch("imag_part", imag_part, e.im);
          if (iteration_capped !== e.capped)
            report_mismatch("iteration_capped", iteration_capped, e.capped);
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_word(int a, int b, int c);
    coef_word_t w;
    w.a = CW'(a);
    w.b = CW'(b);
    w.c = CW'(c);
    coef_pending.push_back(w);
  endtask

  task automatic add_random(int n);
    int a, k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_word(0, $urandom, $urandom);
        1: begin
          a = $urandom_range(1, 8);
          k = $signed($urandom_range(0, 40)) - 20;
          if ($urandom_range(0, 1)) add_word(a, 2 * a * k, a * k * k);
          else add_word(-a, -2 * a * k, -a * k * k);
        end
        2, 3: add_word($signed($urandom_range(0, 64)) - 32, $signed($urandom_range(0, 64)) - 32,
                       $signed($urandom_range(0, 64)) - 32);
        default: add_word($urandom, $urandom, $urandom);
      endcase
    end
  endtask

  task automatic wait_idle();
    while (coef_pending.size() > 0 || in_valid) @(posedge clk);
    while (roots_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TLW-1:0] v);
    @(posedge clk);
    tol_write <= 1'b1;
    tol_data <= v;
    tol_now = v;
    @(posedge clk);
    tol_write <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words on the reset tolerance
    add_word(0, 0, 0);
    add_word(0, 0, 5);
    add_word(0, 0, -32768);
    add_word(0, 3, -32768);
    add_word(0, -32768, 32767);
    add_word(0, 1, -32768);
    add_word(0, -1, 32767);
    add_word(1, 2, 1);
    add_word(-32768, 0, 0);
    add_word(32767, 0, 0);
    add_word(1, 0, -4);
    add_word(1, -32768, -32768);
    add_word(-32768, -32768, 32767);
    add_word(32767, 32767, -32768);
    add_word(1, 0, 1);
    add_word(32767, 0, 32767);
    add_word(-32768, 1, -32768);
    add_word(1, 32767, 0);
    add_word(-1, -32768, 32767);
    add_word(2, 3, 5);
    add_random(500);

    // sender waits for every result
    while (coef_pending.size() > 250) @(posedge clk);
    send_hold = 1'b1;
    while (roots_due.size() > 0 || in_valid) @(posedge clk);
    send_hold = 1'b0;

    // long receiver hold while the sender keeps offering
    long_hold = 3000;
    add_random(300);
    wait_idle();

    set_tolerance('0);
    add_word(1, 0, -2);
    add_word(1, 0, -9);
    add_word(3, 7, 1);
    add_random(20);
    wait_idle();

    set_tolerance('1);
    add_word(1, 0, -2);
    add_word(1, 0, 2);
    add_random(300);
    wait_idle();

    set_tolerance(32'd1);
    add_random(250);
    wait_idle();

    set_tolerance($urandom);
    add_random(150);
    wait_idle();

    set_tolerance($urandom_range(0, 32'h0010_0000));
    add_random(150);
    wait_idle();

    set_tolerance(qrs_pkg::TOL_RESET);
    quiet = 1'b1;
    add_random(150);
    while (coef_pending.size() > 0 || in_valid) @(posedge clk);
    while (roots_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_div.sv
hw/rtl/qrs_queue.sv
hw/rtl/qrs_front.sv
hw/rtl/qrs_back.sv
hw/rtl/quadratic_root_solver.sv
hw/rtl/qrs_checker.sv
dv/tb_quadratic_root_solver.sv
